// ===== design/wrss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the weighted random select sum tree.
// Used by weighted_random_select_sum_tree_core; depends on nothing.
package wrss_pkg;

    localparam int ENTRIES_DEFAULT      = 16;
    localparam int WEIGHT_WIDTH_DEFAULT = 16;

    // Fixed field widths of the item ports.
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 4;
    localparam int WEIGHT_W = 16;
    localparam int RANDOM_W = 32;
    localparam int TOTAL_W  = 20;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADJUST = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DRAW   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_DUP    = 2'd1,
        STAT_ABSENT = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_RD,
        S_UPD_WR,
        S_DIV,
        S_DESC_RD,
        S_DESC_CMP,
        S_DONE
    } state_t;

endpackage

// ===== design/wrss_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with a registered read.
// Stand-alone; no package dependency.
module wrss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/weighted_random_select_sum_tree_core.sv =====
`timescale 1ns / 1ps
// Weighted random selection over a table of entries held as a binary sum tree.
// Depends on wrss_pkg and on wrss_ram, which holds the node sums.
//
// The block keeps ENTRIES weights as the leaves of a complete binary sum tree
// (node 1 is the root, node k has children 2k and 2k+1, entry i sits at leaf
// ENTRIES+i) in a single RAM. An insert or adjust writes the leaf and then
// walks up to the root, reading the sibling of the current node and writing
// the parent as the running sum plus that sibling. A draw first reduces
// random_value modulo the root total with a restoring divider that retires
// one bit per cycle, then descends from the root, reading the left child and
// comparing once per level. Every item returns exactly one result transfer.
// The block handles one item at a time: in_ready is high only while it waits
// for a new item, but a finished result sits in an output register, so the
// next item may be transferred in while the previous result still waits for
// out_ready. After reset the block sweeps the RAM to zero, one node a cycle,
// and holds in_ready low until that pass is over. Status reports a duplicate
// insert, an insert or adjust of an out-of-range entry, an adjust of an
// absent entry, and a draw on an empty total; total_weight is always the
// root sum after the action, truncated to 20 bits.
module weighted_random_select_sum_tree_core #(
    parameter int ENTRIES      = wrss_pkg::ENTRIES_DEFAULT,
    parameter int WEIGHT_WIDTH = wrss_pkg::WEIGHT_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [wrss_pkg::ACTION_W-1:0]      action,
    input  logic [wrss_pkg::INDEX_W-1:0]       entry_index,
    input  logic [wrss_pkg::WEIGHT_W-1:0]      weight,
    input  logic [wrss_pkg::RANDOM_W-1:0]      random_value,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [wrss_pkg::INDEX_W-1:0]       selected_index,
    output logic [wrss_pkg::STATUS_W-1:0]      status,
    output logic [wrss_pkg::TOTAL_W-1:0]       total_weight
);

    import wrss_pkg::*;

    // Only the low bits of the weight port that both the port and the
    // parameter allow reach the tree.
    localparam int W_EFF  = (WEIGHT_WIDTH < WEIGHT_W) ? WEIGHT_WIDTH : WEIGHT_W;
    localparam int SUM_W  = W_EFF + $clog2(ENTRIES);
    localparam int DEPTH  = 2 * ENTRIES;
    localparam int NODE_W = $clog2(DEPTH);
    // The entry index port reaches at most sixteen entries, so only those
    // can ever be marked present.
    localparam int PRES_N = (ENTRIES < (1 << INDEX_W)) ? ENTRIES : (1 << INDEX_W);
    localparam int PRES_W = $clog2(PRES_N);
    localparam int CNT_W  = $clog2(RANDOM_W);

    state_t                state_reg, state_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [SUM_W-1:0]      carry_reg, carry_next;
    logic [SUM_W-1:0]      rem_reg, rem_next;
    logic [SUM_W-1:0]      root_reg, root_next;
    logic [RANDOM_W-1:0]   rnd_reg, rnd_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PRES_N-1:0]     present_reg, present_next;
    logic [INDEX_W-1:0]    sel_reg, sel_next;
    status_t               stat_reg, stat_next;

    logic                  out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]    out_sel_reg, out_sel_next;
    status_t               out_stat_reg, out_stat_next;
    logic [TOTAL_W-1:0]    out_total_reg, out_total_next;

    // RAM access, driven by the sequencer.
    logic                  ram_we;
    logic [NODE_W-1:0]     ram_waddr;
    logic [SUM_W-1:0]      ram_wdata;
    logic [NODE_W-1:0]     ram_raddr;
    logic [SUM_W-1:0]      ram_rdata;

    logic                  in_xfer;
    logic                  idx_ok;
    logic [PRES_W-1:0]     pidx;
    logic [NODE_W-1:0]     leaf_addr;
    logic [SUM_W:0]        rem_shift;
    logic [SUM_W-1:0]      up_sum;
    logic [NODE_W-1:0]     parent;

    wrss_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign idx_ok    = (32'(entry_index) < ENTRIES);
    assign pidx      = entry_index[PRES_W-1:0];
    assign leaf_addr = NODE_W'(ENTRIES) + NODE_W'(entry_index);

    // One bit of the restoring division: shift in the next random bit.
    assign rem_shift = {rem_reg, rnd_reg[RANDOM_W-1]};
    assign up_sum    = carry_reg + ram_rdata;
    assign parent    = node_reg >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            node_reg      <= '0;
            root_reg      <= '0;
            cnt_reg       <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            root_reg      <= root_next;
            cnt_reg       <= cnt_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg     <= carry_next;
        rem_reg       <= rem_next;
        rnd_reg       <= rnd_next;
        sel_reg       <= sel_next;
        stat_reg      <= stat_next;
        out_sel_reg   <= out_sel_next;
        out_stat_reg  <= out_stat_next;
        out_total_reg <= out_total_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        carry_next     = carry_reg;
        rem_next       = rem_reg;
        rnd_next       = rnd_reg;
        cnt_next       = cnt_reg;
        present_next   = present_reg;
        sel_next       = sel_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg;
        out_sel_next   = out_sel_reg;
        out_stat_next  = out_stat_reg;
        out_total_next = out_total_reg;
        ram_we         = 1'b0;
        ram_waddr      = node_reg;
        ram_wdata      = '0;
        ram_raddr      = node_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = node_reg;
                ram_wdata = '0;
                node_next = node_reg + 1'b1;
                if (node_reg == NODE_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_xfer)
                begin
                    sel_next   = '0;
                    stat_next  = STAT_OK;
                    state_next = S_DONE;
                    unique case (action) inside
                        ACT_INSERT, ACT_ADJUST:
                        begin
                            if (!idx_ok)
                            begin
                                stat_next = STAT_ABSENT;
                            end
                            else if (action == ACT_INSERT && present_reg[pidx])
                            begin
                                stat_next = STAT_DUP;
                            end
                            else if (action == ACT_ADJUST && !present_reg[pidx])
                            begin
                                stat_next = STAT_ABSENT;
                            end
                            else
                            begin
                                present_next[pidx] = 1'b1;
                                ram_we     = 1'b1;
                                ram_waddr  = leaf_addr;
                                ram_wdata  = SUM_W'(weight[W_EFF-1:0]);
                                carry_next = SUM_W'(weight[W_EFF-1:0]);
                                node_next  = leaf_addr;
                                state_next = S_UPD_RD;
                            end
                        end
                        ACT_DRAW:
                        begin
                            if (root_reg == '0)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                rem_next   = '0;
                                rnd_next   = random_value;
                                cnt_next   = '0;
                                state_next = S_DIV;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end

            S_UPD_RD:
            begin
                if (node_reg == NODE_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = node_reg ^ NODE_W'(1);
                    state_next = S_UPD_WR;
                end
            end

            S_UPD_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = parent;
                ram_wdata  = up_sum;
                carry_next = up_sum;
                node_next  = parent;
                state_next = S_UPD_RD;
            end

            S_DIV:
            begin
                if (rem_shift >= {1'b0, root_reg})
                begin
                    rem_next = SUM_W'(rem_shift - {1'b0, root_reg});
                end
                else
                begin
                    rem_next = SUM_W'(rem_shift);
                end
                rnd_next = rnd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RANDOM_W - 1))
                begin
                    node_next  = NODE_W'(1);
                    state_next = S_DESC_RD;
                end
            end

            S_DESC_RD:
            begin
                if (32'(node_reg) >= ENTRIES)
                begin
                    sel_next   = INDEX_W'(node_reg - NODE_W'(ENTRIES));
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = node_reg << 1;
                    state_next = S_DESC_CMP;
                end
            end

            S_DESC_CMP:
            begin
                // Below the left sum goes left, else skip over it and go right.
                if (rem_reg < ram_rdata)
                begin
                    node_next = node_reg << 1;
                end
                else
                begin
                    rem_next  = rem_reg - ram_rdata;
                    node_next = (node_reg << 1) | NODE_W'(1);
                end
                state_next = S_DESC_RD;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_sel_next   = sel_reg;
                    out_stat_next  = stat_reg;
                    out_total_next = TOTAL_W'(root_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The root sum is mirrored in a register so that draws and results
        // see it without a RAM read.
        root_next = root_reg;
        if (ram_we && ram_waddr == NODE_W'(1))
        begin
            root_next = ram_wdata;
        end
    end

    assign out_valid      = out_valid_reg;
    assign selected_index = out_sel_reg;
    assign status         = out_stat_reg;
    assign total_weight   = out_total_reg;

    // The running remainder stays below the total throughout the modulo.
    a_rem_below_total: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < root_reg)
    ) else $error("remainder not below total during modulo");

    // Only a successful draw names an entry.
    a_sel_zero_on_error: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> (selected_index == '0)
    ) else $error("entry selected on an error result");

    // Presence marks change only as a result of a transferred item.
    a_present_only_on_xfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_xfer |=> $stable(present_reg)
    ) else $error("presence changed without an input transfer");

    // A draw that succeeds never reports an empty total.
    a_ok_draw_nonempty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_DESC_CMP) |-> (root_reg != '0)
    ) else $error("descent running on an empty tree");

endmodule
